>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// Clocked, reset-qualified property checks that report through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_RST(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Expression must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");

`endif

>>> rtl/ppp_pkg.sv
// ----------------------------------------------------------------------------
// ppp_pkg
// Types and codes shared by the parallel printer port modules.
// ----------------------------------------------------------------------------
package ppp_pkg;

  // Access kind
  localparam logic CmdRead  = 1'b0;
  localparam logic CmdWrite = 1'b1;

  // Port offsets
  localparam logic [1:0] OffData    = 2'd0;
  localparam logic [1:0] OffStatus  = 2'd1;
  localparam logic [1:0] OffControl = 2'd2;
  localparam logic [1:0] OffUnused  = 2'd3;

  // Data read value in input mode
  localparam logic [7:0] DataInputMode = 8'hFF;

  // Control register, bit 5 down to bit 0
  typedef struct packed {
    logic input_mode;
    logic irq_en;
    logic sel_in;
    logic init;
    logic autofeed;
    logic strobe;
  } ppp_ctl_t;

  // Status register, bit 4 down to bit 0
  typedef struct packed {
    logic busy;
    logic ack;
    logic pe;
    logic slct;
    logic error;
  } ppp_status_t;

  localparam ppp_ctl_t    CtlReset    = 6'h0C;
  localparam ppp_status_t StatusReset = 5'h1B;

  // Architectural state of the port
  typedef struct packed {
    logic [7:0]  data;
    ppp_ctl_t    ctl;
    ppp_status_t status;
    logic        init_pend;
    logic        irq;
  } ppp_state_t;

  // One bus request
  typedef struct packed {
    logic       command;
    logic [1:0] port_offset;
    logic [7:0] write_data;
  } ppp_req_t;

  // One response
  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    logic       byte_sent;
    logic [7:0] printer_byte;
  } ppp_rsp_t;

endpackage

>>> rtl/ppp_access.sv
// ----------------------------------------------------------------------------
// ppp_access
// Decodes one bus request against the current port state and produces the
// next state and the response.
// ----------------------------------------------------------------------------
module ppp_access import ppp_pkg::*; (
  input  ppp_req_t   req_i,
  input  ppp_state_t state_i,
  output ppp_state_t state_o,
  output ppp_rsp_t   rsp_o
);

  ppp_ctl_t    wr_ctl;
  logic        strobe_rise;
  logic        init_rise;
  logic        sent;
  ppp_status_t st_rd;

  assign wr_ctl      = ppp_ctl_t'(req_i.write_data[5:0]);
  assign strobe_rise = wr_ctl.strobe & ~state_i.ctl.strobe;
  assign init_rise   = wr_ctl.init & ~state_i.ctl.init;

  // Status read side effects: release ack, then finish a pending init
  always_comb begin
    st_rd     = state_i.status;
    st_rd.ack = 1'b1;
    if (state_i.init_pend) begin
      st_rd.busy = 1'b1;
      st_rd.slct = 1'b1;
      st_rd.ack  = 1'b0;
    end
  end

  always_comb begin
    state_o = state_i;
    rsp_o   = '0;
    sent    = 1'b0;
    if (req_i.command == CmdRead) begin
      unique case (req_i.port_offset)
        OffData: begin
          rsp_o.read_data = state_i.ctl.input_mode ? DataInputMode : state_i.data;
        end
        OffStatus: begin
          rsp_o.read_data = {state_i.status, 3'b000};
          state_o.status  = st_rd;
          if (!state_i.status.ack && state_i.ctl.irq_en) begin
            state_o.irq = 1'b0;
          end
          if (state_i.init_pend) begin
            state_o.init_pend = 1'b0;
            if (state_i.ctl.irq_en) begin
              state_o.irq = 1'b1;
            end
          end
        end
        OffControl: begin
          rsp_o.read_data = {2'b00, state_i.ctl};
        end
        OffUnused: begin
          rsp_o.read_data = '0;
        end
        default: begin
          rsp_o.read_data = '0;
        end
      endcase
    end else begin
      unique case (req_i.port_offset)
        OffData: begin
          state_o.data = req_i.write_data;
        end
        OffControl: begin
          // a strobe rise while slct is set hands the latched byte to the printer
          sent = strobe_rise & state_i.status.slct;
          if (sent) begin
            state_o.status.ack  = 1'b0;
            state_o.status.busy = 1'b1;
            if (state_i.ctl.irq_en) begin
              state_o.irq = 1'b1;
            end
          end
          // init rise drops busy and arms the pending init
          if (init_rise) begin
            state_o.status.busy = 1'b0;
            state_o.init_pend   = 1'b1;
          end
          state_o.status.slct = wr_ctl.sel_in;
          state_o.ctl         = wr_ctl;
        end
        default: begin
          // status and unused offsets ignore writes
        end
      endcase
    end
    rsp_o.irq_line     = state_o.irq;
    rsp_o.byte_sent    = sent;
    rsp_o.printer_byte = sent ? state_i.data : 8'h00;
  end

endmodule

>>> rtl/parallel_printer_port.sv
// ----------------------------------------------------------------------------
// parallel_printer_port
// Standard parallel printer port with data, status and control registers.
// ----------------------------------------------------------------------------
// Usage:
//   Requests (command, port_offset, write_data) enter on a valid/ready
//   channel; each request yields exactly one response (read_data, irq_line,
//   byte_sent, printer_byte) on a second valid/ready channel, in order.
//   A request is held in an input register, then decoded combinationally
//   against the port state; the state and the response register update
//   together. Each request passes the input register, then the response
//   register. Throughput: one request per cycle while responses are taken;
//   the single decode stage lies between input and response register.
//   Reset: both stages empty; data 0, control has init and select-in set,
//   status has busy, ack, slct and error set, interrupt line low.
//   Stall: while the response is not taken, the response register holds and
//   one more request waits in the input register; in_ready_o then drops.
// ----------------------------------------------------------------------------
module parallel_printer_port import ppp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       command_i,
  input  logic [1:0] port_offset_i,
  input  logic [7:0] write_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       irq_line_o,
  output logic       byte_sent_o,
  output logic [7:0] printer_byte_o
);

  logic       in_vld_q;
  ppp_req_t   req_q;
  logic       out_vld_q;
  ppp_rsp_t   rsp_q;
  ppp_rsp_t   rsp_d;
  ppp_state_t state_q;
  ppp_state_t state_d;
  logic       advance;

  // Pipeline handshake
  assign advance    = in_vld_q & (~out_vld_q | out_ready_i);
  assign in_ready_o = ~in_vld_q | advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= '{command: command_i, port_offset: port_offset_i,
                 write_data: write_data_i};
    end
  end

  // Request decode
  ppp_access u_access (
    .req_i   (req_q),
    .state_i (state_q),
    .state_o (state_d),
    .rsp_o   (rsp_d)
  );

  // Port state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{data: 8'h00, ctl: CtlReset, status: StatusReset,
                   init_pend: 1'b0, irq: 1'b0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign read_data_o    = rsp_q.read_data;
  assign irq_line_o     = rsp_q.irq_line;
  assign byte_sent_o    = rsp_q.byte_sent;
  assign printer_byte_o = rsp_q.printer_byte;

endmodule

>>> rtl/ppp_checker.sv
// ----------------------------------------------------------------------------
// ppp_checker
// Port-level checks for the parallel printer port, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ppp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] read_data_o,
  input logic       irq_line_o,
  input logic       byte_sent_o,
  input logic [7:0] printer_byte_o
);

  // A stalled response keeps its payload
  `ASSERT_RST(a_rsp_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_data_o) && $stable(byte_sent_o) && $stable(irq_line_o) && $stable(printer_byte_o))

  // A delivered byte only comes from a write, which reads back zero
  `ASSERT_NEVER(a_sent_rd_zero, clk_i, rst_ni, out_valid_o && byte_sent_o && (read_data_o != 8'h00))

  // Printer byte is zero unless a byte was delivered
  `ASSERT_NEVER(a_pbyte_zero, clk_i, rst_ni, out_valid_o && !byte_sent_o && (printer_byte_o != 8'h00))

  // With the response stage stalled and full, the input stage fills and stops
  `ASSERT_RST(a_backpressure, clk_i, rst_ni, out_valid_o && !out_ready_i && !in_ready_o |=> !in_ready_o || out_ready_i || !out_valid_o)

endmodule

bind parallel_printer_port ppp_checker u_ppp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .read_data_o    (read_data_o),
  .irq_line_o     (irq_line_o),
  .byte_sent_o    (byte_sent_o),
  .printer_byte_o (printer_byte_o)
);
